@@ src/bpig_pkg.sv @@
// ---------------------------------------------------------------------------
// bpig_pkg
// Shared types and constants of the permutation index generator: operation
// and register codes, controller states, command and status bundles.
// ---------------------------------------------------------------------------
package bpig_pkg;

    localparam int STAGE_COUNT_DEF = 4;
    localparam int MAX_WIDTH_DEF   = 64;

    localparam logic [63:0] WEYL_STEP  = 64'h9e3779b97f4a7c15;
    localparam int          WALK_LIMIT = 256;
    localparam int          MULT_ROW   = 64;

    // operation codes of an input word
    typedef enum logic [1:0] {
        OP_NEXT = 2'd0,
        OP_UNDO = 2'd1,
        OP_LOAD = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    // configuration register indexes
    localparam logic [2:0] REG_MAX_VALUE    = 3'd0;
    localparam logic [2:0] REG_SHIFT_FIRST  = 3'd1;
    localparam logic [2:0] REG_SHIFT_SECOND = 3'd2;
    localparam logic [2:0] REG_SHIFT_THIRD  = 3'd3;
    localparam logic [2:0] REG_MULT_FIRST   = 3'd4;
    localparam logic [2:0] REG_MULT_SECOND  = 3'd5;
    localparam logic [2:0] REG_INV_FIRST    = 3'd6;
    localparam logic [2:0] REG_INV_SECOND   = 3'd7;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WEYL_ADD,
        ST_GF_RUN,
        ST_GF_DRAIN,
        ST_STAGE_MUL,
        ST_WEYL_SUB,
        ST_MIX_XS,
        ST_MIX_MUL,
        ST_XSI_INIT,
        ST_XSI_RUN,
        ST_CHECK
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic start_next;
        logic start_undo;
        logic load_word;
        logic weyl_add;
        logic weyl_sub;
        logic gf_start;
        logic gf_issue;
        logic gf_drain;
        logic mul_step;
        logic mul_mix;
        logic stage_clr;
        logic stage_inc;
        logic stage_dec;
        logic stage_set_last;
        logic mix_clr;
        logic mix_inc;
        logic mix_dec;
        logic mix_set_last;
        logic mix_xs;
        logic xsi_init;
        logic xsi_step;
        logic round_inc;
        logic out_load;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic inv;
        logic gf_last;
        logic mul_done;
        logic stage_last;
        logic stage_zero;
        logic mix_last;
        logic mix_zero;
        logic shift_zero;
        logic t_zero;
        logic walk;
        logic out_free;
    } status_t;

endpackage

@@ src/bpig_ctrl.sv @@
// ---------------------------------------------------------------------------
// bpig_ctrl
// Sequencer: walks one word through the stage chain, the mix, the cycle
// walk and the result hand-off by issuing commands to the datapath.
// ---------------------------------------------------------------------------
module bpig_ctrl
    import bpig_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic [1:0] s_operation,
    output logic       s_ready,
    input  status_t    status,
    output cmd_t       cmd
);

    state_t state_reg, state_next;
    logic   accept;

    assign accept = s_valid && (state_reg == ST_IDLE);

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && s_operation == OP_NEXT) begin
                    state_next = ST_WEYL_ADD;
                end else if (accept && s_operation == OP_UNDO) begin
                    state_next = ST_XSI_INIT;
                end
            end
            ST_WEYL_ADD: state_next = ST_GF_RUN;
            ST_GF_RUN: begin
                if (status.gf_last) state_next = ST_GF_DRAIN;
            end
            ST_GF_DRAIN: state_next = status.inv ? ST_WEYL_SUB : ST_STAGE_MUL;
            ST_STAGE_MUL: begin
                if (status.mul_done) begin
                    if (status.inv) begin
                        state_next = ST_GF_RUN;
                    end else if (status.stage_last) begin
                        state_next = ST_MIX_XS;
                    end else begin
                        state_next = ST_WEYL_ADD;
                    end
                end
            end
            ST_WEYL_SUB: state_next = status.stage_zero ? ST_CHECK : ST_STAGE_MUL;
            ST_MIX_XS:   state_next = status.mix_last ? ST_CHECK : ST_MIX_MUL;
            ST_MIX_MUL: begin
                if (status.mul_done) state_next = status.inv ? ST_XSI_INIT : ST_MIX_XS;
            end
            ST_XSI_INIT: begin
                if (status.shift_zero) begin
                    state_next = status.mix_zero ? ST_STAGE_MUL : ST_MIX_MUL;
                end else begin
                    state_next = ST_XSI_RUN;
                end
            end
            ST_XSI_RUN: begin
                if (status.t_zero) state_next = status.mix_zero ? ST_STAGE_MUL : ST_MIX_MUL;
            end
            ST_CHECK: begin
                if (status.walk) begin
                    state_next = status.inv ? ST_XSI_INIT : ST_WEYL_ADD;
                end else if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready        = 1'b1;
                cmd.start_next = accept && s_operation == OP_NEXT;
                cmd.start_undo = accept && s_operation == OP_UNDO;
                cmd.load_word  = accept && s_operation == OP_LOAD;
            end
            ST_WEYL_ADD: begin
                cmd.weyl_add = 1'b1;
                cmd.gf_start = 1'b1;
            end
            ST_GF_RUN:   cmd.gf_issue = 1'b1;
            ST_GF_DRAIN: cmd.gf_drain = 1'b1;
            ST_STAGE_MUL: begin
                cmd.mul_step = 1'b1;
                if (status.mul_done) begin
                    cmd.gf_start  = status.inv;
                    cmd.mix_clr   = !status.inv && status.stage_last;
                    cmd.stage_inc = !status.inv && !status.stage_last;
                end
            end
            ST_WEYL_SUB: begin
                cmd.weyl_sub  = 1'b1;
                cmd.stage_dec = !status.stage_zero;
            end
            ST_MIX_XS:   cmd.mix_xs = 1'b1;
            ST_MIX_MUL: begin
                cmd.mul_step = 1'b1;
                cmd.mul_mix  = 1'b1;
                if (status.mul_done) begin
                    cmd.mix_dec = status.inv;
                    cmd.mix_inc = !status.inv;
                end
            end
            ST_XSI_INIT: begin
                cmd.xsi_init       = !status.shift_zero;
                cmd.stage_set_last = status.shift_zero && status.mix_zero;
            end
            ST_XSI_RUN: begin
                cmd.xsi_step       = !status.t_zero;
                cmd.stage_set_last = status.t_zero && status.mix_zero;
            end
            ST_CHECK: begin
                if (status.walk) begin
                    cmd.round_inc    = 1'b1;
                    cmd.mix_set_last = status.inv;
                    cmd.stage_clr    = !status.inv;
                end else begin
                    cmd.out_load = status.out_free;
                end
            end
            default: ;
        endcase
    end

endmodule

@@ src/bpig_dp.sv @@
// ---------------------------------------------------------------------------
// bpig_dp
// Datapath: configuration registers, position counter, row memory and
// stage multipliers, GF(2) row accumulator, 32x32 multiply unit, xorshift
// logic, walk counter and output register.
// ---------------------------------------------------------------------------
module bpig_dp
    import bpig_pkg::*;
#(
    parameter int STAGE_COUNT = STAGE_COUNT_DEF,
    parameter int MAX_WIDTH   = MAX_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  cmd_t        cmd,
    output status_t     status,
    input  logic [63:0] s_operand_value,
    input  logic [1:0]  s_table_stage,
    input  logic        s_table_inverse,
    input  logic [6:0]  s_table_row,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_result_value,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_wdata
);

    localparam int SW        = (STAGE_COUNT > 1) ? $clog2(STAGE_COUNT) : 1;
    localparam int RW        = $clog2(MAX_WIDTH);
    localparam int ROW_DEPTH = 2 ** (1 + SW + RW);
    localparam int AW        = 1 + SW + RW;

    // configuration
    logic [63:0] max_reg, mult1_reg, mult2_reg, inv1_reg, inv2_reg;
    logic [5:0]  sh1_reg, sh2_reg, sh3_reg;

    // working state
    logic [63:0]          counter_reg, counter_next;
    logic [63:0]          v_reg, v_next;
    logic [MAX_WIDTH-1:0] mask_reg, mask_next, mask_calc;
    logic                 inv_reg, inv_next;
    logic [SW-1:0]        stage_reg, stage_next;
    logic [1:0]           mix_reg, mix_next;
    logic [7:0]           rounds_reg, rounds_next;
    logic [RW-1:0]        j_reg, j_next, rd_j_reg;
    logic                 pend_reg;
    logic [63:0]          gf_acc_reg, gf_acc_next, rdata_reg;
    logic [1:0]           mstep_reg, mstep_next;
    logic [63:0]          macc_reg, macc_next;
    logic [63:0]          t_reg, t_next;
    logic                 out_valid_reg, out_valid_next;
    logic [63:0]          out_reg;

    logic [63:0] row_mem [ROW_DEPTH];
    logic [63:0] mult_mem [2][STAGE_COUNT];

    logic [63:0]          mask64, mul_b, gf_acc_new;
    logic [5:0]           shift_sel;
    logic [MAX_WIDTH-1:0] v_low, mask_hi;
    logic [31:0]          pa, pb;
    logic [63:0]          prod;
    logic                 load_ok, load_row, load_mult;
    logic [AW-1:0]        wr_addr, rd_addr;

    // width mask from the largest value
    always_comb begin
        for (int i = 0; i < MAX_WIDTH; i++) begin
            mask_calc[i] = (i == 0) ? 1'b1 : ((max_reg >> i) != 64'd0);
        end
    end

    assign mask64  = 64'(mask_reg);
    assign mask_hi = mask_reg >> 1;
    assign v_low   = v_reg[MAX_WIDTH-1:0];

    // mix shift select
    always_comb begin
        case (mix_reg)
            2'd0:    shift_sel = sh1_reg;
            2'd1:    shift_sel = sh2_reg;
            default: shift_sel = sh3_reg;
        endcase
    end

    // multiplier operand select
    always_comb begin
        if (!cmd.mul_mix) begin
            mul_b = mult_mem[inv_reg][stage_reg];
        end else if (inv_reg) begin
            mul_b = (mix_reg == 2'd2) ? inv2_reg : inv1_reg;
        end else begin
            mul_b = (mix_reg == 2'd0) ? mult1_reg : mult2_reg;
        end
    end

    // low 64 bits of the product in three 32x32 partial products
    always_comb begin
        case (mstep_reg)
            2'd0:    begin pa = v_reg[31:0];  pb = mul_b[31:0];  end
            2'd1:    begin pa = v_reg[31:0];  pb = mul_b[63:32]; end
            default: begin pa = v_reg[63:32]; pb = mul_b[31:0];  end
        endcase
    end
    assign prod = pa * pb;

    assign gf_acc_new = gf_acc_reg ^ ((pend_reg && v_low[rd_j_reg]) ? rdata_reg : 64'd0);

    // table load decode
    assign load_ok   = cmd.load_word && (32'(s_table_stage) < STAGE_COUNT);
    assign load_mult = load_ok && (32'(s_table_row) == MULT_ROW);
    assign load_row  = load_ok && !load_mult && (32'(s_table_row) < MAX_WIDTH);
    assign wr_addr   = {s_table_inverse, SW'(s_table_stage), RW'(s_table_row)};
    assign rd_addr   = {inv_reg, stage_reg, j_reg};

    // next values of the working registers
    always_comb begin
        counter_next   = counter_reg;
        v_next         = v_reg;
        mask_next      = mask_reg;
        inv_next       = inv_reg;
        stage_next     = stage_reg;
        mix_next       = mix_reg;
        rounds_next    = rounds_reg;
        j_next         = j_reg;
        gf_acc_next    = gf_acc_new;
        mstep_next     = mstep_reg;
        macc_next      = macc_reg;
        t_next         = t_reg;
        out_valid_next = out_valid_reg && !m_ready;

        if (cmd.start_next) begin
            v_next       = counter_reg;
            counter_next = (counter_reg < max_reg) ? counter_reg + 64'd1 : 64'd0;
            mask_next    = mask_calc;
            inv_next     = 1'b0;
            stage_next   = '0;
            rounds_next  = '0;
        end
        if (cmd.start_undo) begin
            v_next      = s_operand_value & 64'(mask_calc);
            mask_next   = mask_calc;
            inv_next    = 1'b1;
            mix_next    = 2'd2;
            rounds_next = '0;
        end
        if (cmd.weyl_add) v_next = v_reg + WEYL_STEP;
        if (cmd.weyl_sub) v_next = (v_reg - WEYL_STEP) & mask64;

        // GF(2) product, one row per cycle
        if (cmd.gf_start) begin
            gf_acc_next = '0;
            j_next      = '0;
        end
        if (cmd.gf_issue) j_next = j_reg + 1'b1;
        if (cmd.gf_drain) v_next = gf_acc_new;

        // multiply and mask
        if (cmd.mul_step) begin
            case (mstep_reg)
                2'd0: begin
                    macc_next  = prod;
                    mstep_next = 2'd1;
                end
                2'd1: begin
                    macc_next  = macc_reg + {prod[31:0], 32'd0};
                    mstep_next = 2'd2;
                end
                default: begin
                    v_next     = (macc_reg + {prod[31:0], 32'd0}) & mask64;
                    mstep_next = 2'd0;
                end
            endcase
        end

        // xorshift, forward and inverse
        if (cmd.mix_xs)   v_next = v_reg ^ (v_reg >> shift_sel);
        if (cmd.xsi_init) t_next = v_reg >> shift_sel;
        if (cmd.xsi_step) begin
            v_next = v_reg ^ t_reg;
            t_next = t_reg >> shift_sel;
        end

        // counters
        if (cmd.stage_clr)      stage_next = '0;
        if (cmd.stage_inc)      stage_next = stage_reg + 1'b1;
        if (cmd.stage_dec)      stage_next = stage_reg - 1'b1;
        if (cmd.stage_set_last) stage_next = SW'(STAGE_COUNT - 1);
        if (cmd.mix_clr)        mix_next = 2'd0;
        if (cmd.mix_inc)        mix_next = mix_reg + 2'd1;
        if (cmd.mix_dec)        mix_next = mix_reg - 2'd1;
        if (cmd.mix_set_last)   mix_next = 2'd2;
        if (cmd.round_inc)      rounds_next = rounds_reg + 8'd1;
        if (cmd.out_load)       out_valid_next = 1'b1;
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            counter_reg   <= '0;
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
            mstep_reg     <= '0;
            max_reg       <= '1;
            sh1_reg       <= 6'd1;
            sh2_reg       <= 6'd1;
            sh3_reg       <= 6'd1;
            mult1_reg     <= 64'd1;
            mult2_reg     <= 64'd1;
            inv1_reg      <= 64'd1;
            inv2_reg      <= 64'd1;
        end else begin
            counter_reg   <= counter_next;
            out_valid_reg <= out_valid_next;
            pend_reg      <= cmd.gf_issue;
            mstep_reg     <= mstep_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_MAX_VALUE:    max_reg   <= cfg_wdata;
                    REG_SHIFT_FIRST:  sh1_reg   <= cfg_wdata[5:0];
                    REG_SHIFT_SECOND: sh2_reg   <= cfg_wdata[5:0];
                    REG_SHIFT_THIRD:  sh3_reg   <= cfg_wdata[5:0];
                    REG_MULT_FIRST:   mult1_reg <= cfg_wdata;
                    REG_MULT_SECOND:  mult2_reg <= cfg_wdata;
                    REG_INV_FIRST:    inv1_reg  <= cfg_wdata;
                    REG_INV_SECOND:   inv2_reg  <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        v_reg      <= v_next;
        mask_reg   <= mask_next;
        inv_reg    <= inv_next;
        stage_reg  <= stage_next;
        mix_reg    <= mix_next;
        rounds_reg <= rounds_next;
        j_reg      <= j_next;
        rd_j_reg   <= j_reg;
        gf_acc_reg <= gf_acc_next;
        macc_reg   <= macc_next;
        t_reg      <= t_next;
        if (cmd.out_load) out_reg <= v_reg;
    end

    // matrix rows and stage multipliers
    always_ff @(posedge aclk) begin
        if (load_row) row_mem[wr_addr] <= s_operand_value;
        if (cmd.gf_issue) rdata_reg <= row_mem[rd_addr];
        if (load_mult) mult_mem[s_table_inverse][SW'(s_table_stage)] <= s_operand_value;
    end

    // status
    assign status.inv        = inv_reg;
    assign status.gf_last    = !mask_hi[j_reg];
    assign status.mul_done   = (mstep_reg == 2'd2);
    assign status.stage_last = (stage_reg == SW'(STAGE_COUNT - 1));
    assign status.stage_zero = (stage_reg == '0);
    assign status.mix_last   = (mix_reg == 2'd2);
    assign status.mix_zero   = (mix_reg == 2'd0);
    assign status.shift_zero = (shift_sel == 6'd0);
    assign status.t_zero     = (t_reg == 64'd0);
    assign status.walk       = (v_reg > max_reg) && (rounds_reg != 8'(WALK_LIMIT - 1));
    assign status.out_free   = !out_valid_reg || m_ready;

    assign m_valid        = out_valid_reg;
    assign m_result_value = out_reg;

endmodule

@@ src/bijective_permutation_index_generator.sv @@
// ---------------------------------------------------------------------------
// bijective_permutation_index_generator
// Emits every value 0..max_value once in a table-defined pseudo-random order,
// and inverts a value back to its position.
// ---------------------------------------------------------------------------
// Usage:
//   s_* input words carry an operation: next (emit the value at the current
//   position, then advance the position), undo (recover the position of
//   s_operand_value) or load (write one matrix row or stage multiplier).
//   next and undo give one m_* result word each; load and the spare code
//   give none. cfg_* writes the mix and width registers; the user must
//   write them only while idle, which the block itself does not enforce.
//   A round of next runs, per stage, a Weyl add, a GF(2) product reading
//   one matrix row per cycle, W rows with W the bit length of max_value,
//   and a multiply from 32x32 partial products on one multiplier, then the
//   mix. An undo round runs each inverse xorshift until its shifted term is
//   zero. Values above max_value walk through further rounds, at most 256 in
//   all. One word is worked on at a time; a new word is taken as soon as the
//   result sits in the output register, and a finished result waits there
//   while m_ready is low. Reset sets the position to zero and the registers
//   to their defaults; the tables hold nothing until loaded.
// ---------------------------------------------------------------------------
module bijective_permutation_index_generator
    import bpig_pkg::*;
#(
    parameter int STAGE_COUNT = STAGE_COUNT_DEF,
    parameter int MAX_WIDTH   = MAX_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic [63:0] s_operand_value,
    input  logic [1:0]  s_table_stage,
    input  logic        s_table_inverse,
    input  logic [6:0]  s_table_row,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_result_value,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_wdata
);

    cmd_t    cmd;
    status_t status;

    bpig_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_operation (s_operation),
        .s_ready     (s_ready),
        .status      (status),
        .cmd         (cmd)
    );

    bpig_dp #(
        .STAGE_COUNT (STAGE_COUNT),
        .MAX_WIDTH   (MAX_WIDTH)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .s_operand_value (s_operand_value),
        .s_table_stage   (s_table_stage),
        .s_table_inverse (s_table_inverse),
        .s_table_row     (s_table_row),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_result_value  (m_result_value),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata)
    );

endmodule

@@ dv/tb_bijective_permutation_index_generator.sv @@
// ---------------------------------------------------------------------------
// tb_bijective_permutation_index_generator
// Self-checking bench for the permutation index generator. A scoreboard
// class carries its own model of the rounds, the mix and the cycle walk, and
// predicts every next and undo word. It first loads invertible tables, then
// runs directed words and then randomized phases under several register
// settings. The sender bursts and the receiver stalls; one long receiver
// hold-off backs the block up into its input.
// ---------------------------------------------------------------------------
module tb_bijective_permutation_index_generator
    import bpig_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    // scoreboard with built-in permutation predictor
    class perm_scoreboard;
        logic [63:0] max_val;
        logic [5:0]  shamt [3];
        logic [63:0] mix_mul1, mix_mul2, mix_inv1, mix_inv2;
        logic [63:0] position;
        logic [63:0] fwd_rows [4][64];
        logic [63:0] inv_rows [4][64];
        logic [63:0] fwd_mul [4];
        logic [63:0] inv_mul [4];
        logic [63:0] expected_q [$];
        int errors;
        int checked;
        int n_next, n_undo, n_load;

        function new();
            max_val  = '1;
            shamt[0] = 6'd1;
            shamt[1] = 6'd1;
            shamt[2] = 6'd1;
            mix_mul1 = 64'd1;
            mix_mul2 = 64'd1;
            mix_inv1 = 64'd1;
            mix_inv2 = 64'd1;
            position = '0;
            errors   = 0;
            checked  = 0;
            n_next   = 0;
            n_undo   = 0;
            n_load   = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [63:0] d);
            case (idx)
                REG_MAX_VALUE:    max_val  = d;
                REG_SHIFT_FIRST:  shamt[0] = d[5:0];
                REG_SHIFT_SECOND: shamt[1] = d[5:0];
                REG_SHIFT_THIRD:  shamt[2] = d[5:0];
                REG_MULT_FIRST:   mix_mul1 = d;
                REG_MULT_SECOND:  mix_mul2 = d;
                REG_INV_FIRST:    mix_inv1 = d;
                default:          mix_inv2 = d;
            endcase
        endfunction

        function int bit_len();
            int n;
            n = 1;
            while (n < 64 && (max_val >> n) != 0) n++;
            return n;
        endfunction

        function logic [63:0] gf2_mul(bit inv, int st, logic [63:0] v, int w);
            logic [63:0] acc;
            acc = '0;
            for (int j = 0; j < w; j++)
                if (v[j]) acc ^= inv ? inv_rows[st][j] : fwd_rows[st][j];
            return acc;
        endfunction

        // exact inverse of x ^= x >> s; zero shift stays identity
        function logic [63:0] unshift(logic [63:0] x, logic [5:0] s);
            logic [63:0] y, t;
            y = x;
            t = x;
            if (s == 0) return x;
            while (t != 0) begin
                t = t >> s;
                y ^= t;
            end
            return y;
        endfunction

        function logic [63:0] fwd_round(logic [63:0] z, int w, logic [63:0] m);
            for (int i = 0; i < 4; i++) begin
                z = z + WEYL_STEP;
                z = (gf2_mul(1'b0, i, z, w) * fwd_mul[i]) & m;
            end
            z ^= z >> shamt[0];
            z = (z * mix_mul1) & m;
            z ^= z >> shamt[1];
            z = (z * mix_mul2) & m;
            z ^= z >> shamt[2];
            return z;
        endfunction

        function logic [63:0] inv_round(logic [63:0] x, int w, logic [63:0] m);
            x = unshift(x, shamt[2]);
            x = (x * mix_inv2) & m;
            x = unshift(x, shamt[1]);
            x = (x * mix_inv1) & m;
            x = unshift(x, shamt[0]);
            for (int i = 3; i >= 0; i--) begin
                x = (x * inv_mul[i]) & m;
                x = (gf2_mul(1'b1, i, x, w) - WEYL_STEP) & m;
            end
            return x;
        endfunction

        // accepted input word: update state, queue the expected value
        function void note_word(op_t op, logic [63:0] val, logic [1:0] st,
                                logic inv, logic [6:0] row);
            int w, rounds;
            logic [63:0] m, v;
            w = bit_len();
            m = (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
            rounds = 0;
            case (op)
                OP_NEXT: begin
                    n_next++;
                    v = position;
                    position = (position < max_val) ? position + 64'd1 : '0;
                    do begin
                        v = fwd_round(v, w, m);
                        rounds++;
                    end while (v > max_val && rounds < WALK_LIMIT);
                    expected_q.push_back(v);
                end
                OP_UNDO: begin
                    n_undo++;
                    v = val & m;
                    do begin
                        v = inv_round(v, w, m);
                        rounds++;
                    end while (v > max_val && rounds < WALK_LIMIT);
                    expected_q.push_back(v);
                end
                OP_LOAD: begin
                    n_load++;
                    if (row == MULT_ROW) begin
                        if (inv) inv_mul[st] = val;
                        else fwd_mul[st] = val;
                    end else if (row < 64) begin
                        if (inv) inv_rows[st][row] = val;
                        else fwd_rows[st][row] = val;
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_word(logic [63:0] act);
            logic [63:0] exp_val;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result word, actual %h", $time, act);
                return;
            end
            exp_val = expected_q.pop_front();
            checked++;
            if (act !== exp_val) begin
                errors++;
                $display("%0t: result_value mismatch, expected %h actual %h",
                         $time, exp_val, act);
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_operation = OP_NONE;
    logic [63:0] s_operand_value = '0;
    logic [1:0]  s_table_stage = '0;
    logic        s_table_inverse = 1'b0;
    logic [6:0]  s_table_row = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [63:0] m_result_value;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_wdata = '0;

    perm_scoreboard sb = new();
    int burst_left = 0;
    bit held_once = 0;
    int phases_run = 0;

    bijective_permutation_index_generator dut (.*);

    initial begin
        forever #2 aclk = ~aclk;
    end

    // run limit
    initial begin
        #400_000_000;
        $display("tb_bijective_permutation_index_generator failed");
        $finish;
    end

    // monitor both channels at the edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.note_word(op_t'(s_operation), s_operand_value, s_table_stage,
                             s_table_inverse, s_table_row);
            if (m_valid && m_ready)
                sb.check_word(m_result_value);
        end
    end

    // receiver: rotating stall pattern plus one long hold-off
    initial begin
        int cyc;
        cyc = 0;
        wait (aresetn);
        forever begin
            @(posedge aclk);
            cyc++;
            if (!held_once && sb.checked >= 40) begin
                held_once = 1;
                m_ready <= 1'b0;
                repeat (3000) @(posedge aclk);
            end else begin
                case ((cyc / 97) % 3)
                    0: m_ready <= 1'b1;
                    1: m_ready <= ($urandom_range(0, 3) != 0);
                    default: m_ready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // one input word, with burst and gap handling
    task automatic send_word(op_t op, logic [63:0] val, logic [1:0] st,
                             logic inv, logic [6:0] row);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_valid         <= 1'b1;
        s_operation     <= op;
        s_operand_value <= val;
        s_table_stage   <= st;
        s_table_inverse <= inv;
        s_table_row     <= row;
        do @(posedge aclk); while (!s_ready);
        burst_left--;
    endtask

    // lower-triangular row with unit diagonal keeps each stage invertible
    task automatic load_row(logic inv, logic [1:0] st, int j);
        logic [63:0] d;
        d = (64'd1 << j) | (rand64() & ((64'd1 << j) - 64'd1));
        send_word(OP_LOAD, d, st, inv, 7'(j));
    endtask

    task automatic load_tables();
        for (int t = 0; t < 2; t++)
            for (int st = 0; st < 4; st++) begin
                for (int j = 0; j < 64; j++) load_row(t[0], st[1:0], j);
                send_word(OP_LOAD, rand64() | 64'd1, st[1:0], t[0], 7'(MULT_ROW));
            end
    endtask

    // drain outstanding results, then let the block settle
    task automatic settle();
        s_valid <= 1'b0;
        burst_left = 0;
        // let the monitor record the last accepted word first
        @(posedge aclk);
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
    endtask

    task automatic write_regs(logic [63:0] vals [8]);
        for (int i = 0; i < 8; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= 3'(i);
            cfg_wdata <= vals[i];
            sb.write_reg(3'(i), vals[i]);
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    task automatic random_word();
        int r;
        logic [63:0] v;
        r = $urandom_range(0, 99);
        if (r < 45) begin
            send_word(OP_NEXT, rand64(), 2'($urandom), 1'($urandom), 7'($urandom));
        end else if (r < 80) begin
            case ($urandom_range(0, 3))
                0: v = '1;
                1: v = 64'($urandom_range(0, 300));
                default: v = rand64();
            endcase
            send_word(OP_UNDO, v, 2'($urandom), 1'($urandom), 7'($urandom));
        end else if (r < 88) begin
            if ($urandom_range(0, 7) == 0)
                send_word(OP_LOAD, rand64() | 64'd1, 2'($urandom), 1'($urandom),
                          7'(MULT_ROW));
            else
                load_row(1'($urandom), 2'($urandom), $urandom_range(0, 63));
        end else if (r < 94) begin
            send_word(OP_NONE, rand64(), 2'($urandom), 1'($urandom), 7'($urandom));
        end else begin
            // row beyond the multiplier slot: must be ignored
            send_word(OP_LOAD, rand64(), 2'($urandom), 1'($urandom),
                      7'($urandom_range(65, 127)));
        end
    endtask

    function automatic logic [63:0] pick_max(int p);
        case (p)
            1: return 64'd0;
            2: return 64'd1;
            3: return '1;
            4: return 64'h8000_0000_0000_0000;
            5: return 64'd255;
            6: return 64'd200;
            7: return 64'hffff_ffff;
            default: return 64'($urandom_range(2, 5000));
        endcase
    endfunction

    function automatic logic [5:0] pick_shift(int p);
        case ($urandom_range(0, 5))
            0: return 6'd1;
            1: return 6'd63;
            2: return (p == 9) ? 6'd0 : 6'd1;
            default: return 6'($urandom_range(1, 63));
        endcase
    endfunction

    function automatic logic [63:0] pick_mult();
        case ($urandom_range(0, 4))
            0: return 64'd1;
            1: return '1;
            default: return rand64() | 64'd1;
        endcase
    endfunction

    // main sequence
    initial begin
        logic [63:0] regs [8];
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        load_tables();

        // directed words at reset settings
        send_word(OP_NEXT, '0, 2'd0, 1'b0, 7'd0);
        send_word(OP_NEXT, '1, 2'd3, 1'b1, 7'd127);
        send_word(OP_NEXT, '0, 2'd0, 1'b0, 7'd0);
        send_word(OP_UNDO, '0, 2'd0, 1'b0, 7'd0);
        send_word(OP_UNDO, '1, 2'd3, 1'b1, 7'd127);
        send_word(OP_UNDO, 64'h8000_0000_0000_0000, 2'd1, 1'b0, 7'd64);
        send_word(OP_NONE, '1, 2'd3, 1'b1, 7'd64);
        send_word(OP_LOAD, '1, 2'd2, 1'b0, 7'd65);
        send_word(OP_LOAD, '1, 2'd3, 1'b1, 7'd127);
        send_word(OP_LOAD, '1, 2'd3, 1'b1, 7'(MULT_ROW));
        send_word(OP_LOAD, 64'h8000_0000_0000_0001, 2'd0, 1'b0, 7'(MULT_ROW));
        send_word(OP_NEXT, '0, 2'd0, 1'b0, 7'd0);
        send_word(OP_UNDO, rand64(), 2'd0, 1'b0, 7'd0);
        settle();

        // max zero with the counter above it, then a short wrap run
        regs = '{64'd0, 64'd1, 64'd1, 64'd1, 64'd1, 64'd1, 64'd1, 64'd1};
        write_regs(regs);
        repeat (4) send_word(OP_NEXT, '0, 2'd0, 1'b0, 7'd0);
        send_word(OP_UNDO, '1, 2'd0, 1'b0, 7'd0);
        settle();

        for (int p = 1; p <= 13; p++) begin
            regs[0] = pick_max(p);
            regs[1] = 64'(pick_shift(p));
            regs[2] = 64'(pick_shift(p));
            regs[3] = (p == 9) ? 64'd0 : 64'(pick_shift(p));
            regs[4] = pick_mult();
            regs[5] = pick_mult();
            regs[6] = pick_mult();
            regs[7] = pick_mult();
            if (p == 10) regs = '{64'd300, 64'd63, 64'd63, 64'd63, '1, '1, '1, '1};
            write_regs(regs);
            repeat (110) random_word();
            settle();
            phases_run++;
        end

        repeat (200) @(posedge aclk);
        $display("Covered %0d next, %0d undo and %0d load words over %0d phases;",
                 sb.n_next, sb.n_undo, sb.n_load, phases_run + 2);
        $display("%0d results checked, %0d mismatches.", sb.checked, sb.errors);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("tb_bijective_permutation_index_generator passed");
        else
            $display("tb_bijective_permutation_index_generator failed");
        $finish;
    end

endmodule
